// File: hdl/skt_pkg.sv
package skt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [31:0] grade_bits;
        logic [31:0] name_ref;
        logic [3:0]  position;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_key;
        logic [31:0] read_grade;
        logic [31:0] read_name;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic [31:0] min_key;
        logic [31:0] max_key;
    } t_rsp;

    // data carried with a key through the cell row
    typedef struct packed {
        logic [31:0] grade;
        logic [31:0] name;
    } t_rec;

    // compare results a cell reports to its neighbor and to the top level
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// File: hdl/skt_cell.sv
module skt_cell #(
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_shift_en,
    input  logic                 i_occupied,
    input  logic                 i_prev_lt,
    input  logic [KEY_BITS-1:0]  i_prev_key,
    input  skt_pkg::t_rec        i_prev_rec,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  skt_pkg::t_rec        i_new_rec,
    output skt_pkg::t_cell_flags o_flags,
    output logic [KEY_BITS-1:0]  o_key,
    output skt_pkg::t_rec        o_rec
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    skt_pkg::t_rec       r_rec;
    skt_pkg::t_rec       n_rec;
    logic                w_load;

    assign o_flags.lt = i_occupied && (r_key < i_new_key);
    assign o_flags.eq = i_occupied && (r_key == i_new_key);

    // cells below the insertion slot hold; the slot takes the new record,
    // everything above it takes the neighbor's record
    assign w_load = i_shift_en && !o_flags.lt;

    always_comb begin
        if (i_prev_lt) begin
            n_key = i_new_key;
            n_rec = i_new_rec;
        end else begin
            n_key = i_prev_key;
            n_rec = i_prev_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key <= n_key;
            r_rec <= n_rec;
        end
    end

    assign o_key = r_key;
    assign o_rec = r_rec;

endmodule

// File: hdl/sorted_key_table.sv
// Channel    Direction  Handshake                    Payload
// request    in         i_req_valid / o_req_ready    i_req  (skt_pkg::t_req)
// response   out        o_rsp_valid / i_rsp_ready    o_rsp  (skt_pkg::t_rsp)
//
// One request per clock unless the response is stalled. Its response
// is registered and appears the cycle after acceptance; every cell compares
// the request key in parallel and the row shifts in the same edge.
// Reset clears the record count and the response valid; stored records are
// unknown until written. A stalled response holds, and a new request is
// taken in the cycle the pending response leaves.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  skt_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output skt_pkg::t_rsp o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int POS_W = CNT_W + 4;

    logic                  r_rsp_valid;
    skt_pkg::t_rsp         r_rsp;
    skt_pkg::t_rsp         n_rsp;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [KEY_BITS-1:0]   r_max;
    logic [KEY_BITS-1:0]   n_max;

    logic                  w_accept;
    logic                  w_insert;
    logic                  w_dup;
    logic                  w_full;
    logic                  w_ins_ok;
    logic                  w_append;
    logic                  w_rd_hit;
    logic [KEY_BITS+31:0]  w_key_ext;
    logic [KEY_BITS-1:0]   w_new_key;
    skt_pkg::t_rec         w_new_rec;
    logic [KEY_BITS-1:0]   w_min;
    logic [POS_W-1:0]      w_pos_ext;
    logic [POS_W-1:0]      w_cnt_ext;
    logic [IDX_W+3:0]      w_pos_wide;
    logic [IDX_W-1:0]      w_pos_idx;
    logic [KEY_BITS+31:0]  w_rd_key_ext;
    logic [KEY_BITS+31:0]  w_min_ext;
    logic [KEY_BITS+31:0]  w_max_ext;
    logic [CNT_W+4:0]      w_cnt_out;

    logic [CAPACITY-1:0]   w_occ;
    logic [CAPACITY-1:0]   w_lt;
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_prev_lt;
    logic [KEY_BITS-1:0]   w_cell_key [CAPACITY];
    skt_pkg::t_rec         w_cell_rec [CAPACITY];
    skt_pkg::t_cell_flags  w_flags    [CAPACITY];

    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;

    assign w_key_ext       = {{KEY_BITS{1'b0}}, i_req.key};
    assign w_new_key       = w_key_ext[KEY_BITS-1:0];
    assign w_new_rec.grade = i_req.grade_bits;
    assign w_new_rec.name  = i_req.name_ref;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_occ[gi] = CNT_W'(gi) < r_count;
            assign w_lt[gi]  = w_flags[gi].lt;
            assign w_eq[gi]  = w_flags[gi].eq;

            if (gi == 0) begin : g_head
                // the head cell is the slot whenever its key is not smaller
                assign w_prev_lt[gi] = 1'b1;
                skt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_shift_en (w_ins_ok),
                    .i_occupied (w_occ[gi]),
                    .i_prev_lt  (w_prev_lt[gi]),
                    .i_prev_key (w_new_key),
                    .i_prev_rec (w_new_rec),
                    .i_new_key  (w_new_key),
                    .i_new_rec  (w_new_rec),
                    .o_flags    (w_flags[gi]),
                    .o_key      (w_cell_key[gi]),
                    .o_rec      (w_cell_rec[gi])
                );
            end else begin : g_body
                assign w_prev_lt[gi] = w_lt[gi-1];
                skt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .i_clk      (i_clk),
                    .i_shift_en (w_ins_ok),
                    .i_occupied (w_occ[gi]),
                    .i_prev_lt  (w_prev_lt[gi]),
                    .i_prev_key (w_cell_key[gi-1]),
                    .i_prev_rec (w_cell_rec[gi-1]),
                    .i_new_key  (w_new_key),
                    .i_new_rec  (w_new_rec),
                    .o_flags    (w_flags[gi]),
                    .o_key      (w_cell_key[gi]),
                    .o_rec      (w_cell_rec[gi])
                );
            end
        end
    endgenerate

    assign w_insert = (i_req.op == skt_pkg::OP_INSERT);
    assign w_dup    = |w_eq;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_ins_ok = w_accept && w_insert && !w_dup && !w_full;
    // new key lands past every stored key
    assign w_append = &(w_lt | ~w_occ);

    assign w_pos_ext  = {{CNT_W{1'b0}}, i_req.position};
    assign w_cnt_ext  = {4'd0, r_count};
    assign w_rd_hit   = w_pos_ext < w_cnt_ext;
    assign w_pos_wide = {{IDX_W{1'b0}}, i_req.position};
    assign w_pos_idx  = w_pos_wide[IDX_W-1:0];

    always_comb begin
        n_count = r_count;
        n_max   = r_max;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
            if (w_append) begin
                n_max = w_new_key;
            end
        end
    end

    assign w_min = (w_ins_ok && !w_lt[0]) ? w_new_key : w_cell_key[0];

    assign w_rd_key_ext = {32'd0, w_cell_key[w_pos_idx]};
    assign w_min_ext    = {32'd0, w_min};
    assign w_max_ext    = {32'd0, n_max};
    assign w_cnt_out    = {5'd0, n_count};

    always_comb begin
        n_rsp             = '0;
        n_rsp.status      = skt_pkg::ST_OK;
        n_rsp.entry_count = w_cnt_out[4:0];
        n_rsp.is_empty    = (n_count == '0);
        if (n_count != '0) begin
            n_rsp.min_key = w_min_ext[31:0];
            n_rsp.max_key = w_max_ext[31:0];
        end
        if (w_insert) begin
            if (w_dup) begin
                n_rsp.status = skt_pkg::ST_DUP;
            end else if (w_full) begin
                n_rsp.status = skt_pkg::ST_FULL;
            end
        end else if (w_rd_hit) begin
            n_rsp.read_key   = w_rd_key_ext[31:0];
            n_rsp.read_grade = w_cell_rec[w_pos_idx].grade;
            n_rsp.read_name  = w_cell_rec[w_pos_idx].name;
        end else begin
            n_rsp.status = skt_pkg::ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
        r_max <= n_max;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// File: tb/sv/sorted_key_table_chk.sv
`timescale 1ns / 100ps

module sorted_key_table_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  skt_pkg::t_req  i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  skt_pkg::t_rsp  i_rsp,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked,
    output int             o_full_refusals,
    output int             o_dup_refusals
);

    localparam int CAP = skt_pkg::CAPACITY_DEF;
    localparam int PRINT_LIMIT = 20;

    logic [31:0]    tbl_key   [CAP];
    logic [31:0]    tbl_grade [CAP];
    logic [31:0]    tbl_name  [CAP];
    int             tbl_count;
    skt_pkg::t_rsp  expected_rsp [$];

    // Apply one request to the shadow table and return the response it earns.
    function automatic skt_pkg::t_rsp apply_table_op(input skt_pkg::t_req r);
        skt_pkg::t_rsp p;
        int            slot;
        p = '0;
        p.status = skt_pkg::ST_OK;
        if (r.op == skt_pkg::OP_INSERT) begin
            slot = 0;
            while (slot < tbl_count && tbl_key[slot] < r.key)
                slot++;
            if (slot < tbl_count && tbl_key[slot] == r.key) begin
                p.status = skt_pkg::ST_DUP;
            end else if (tbl_count >= CAP) begin
                p.status = skt_pkg::ST_FULL;
            end else begin
                // open a hole at the sorted slot
                for (int j = tbl_count; j > slot; j--) begin
                    tbl_key[j]   = tbl_key[j - 1];
                    tbl_grade[j] = tbl_grade[j - 1];
                    tbl_name[j]  = tbl_name[j - 1];
                end
                tbl_key[slot]   = r.key;
                tbl_grade[slot] = r.grade_bits;
                tbl_name[slot]  = r.name_ref;
                tbl_count++;
            end
        end else if (r.position < tbl_count) begin
            p.read_key   = tbl_key[r.position];
            p.read_grade = tbl_grade[r.position];
            p.read_name  = tbl_name[r.position];
        end else begin
            p.status = skt_pkg::ST_RANGE;
        end
        p.entry_count = 5'(tbl_count);
        p.is_empty    = (tbl_count == 0);
        if (tbl_count > 0) begin
            p.min_key = tbl_key[0];
            p.max_key = tbl_key[tbl_count - 1];
        end
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_errors < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, expected %h", what, got, want));
    endtask

    always @(posedge i_clk) begin
        skt_pkg::t_rsp want;
        if (!i_rst_n) begin
            tbl_count       = 0;
            o_errors        = 0;
            o_checked       = 0;
            o_full_refusals = 0;
            o_dup_refusals  = 0;
            expected_rsp.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                want = apply_table_op(i_req);
                if (want.status == skt_pkg::ST_FULL)
                    o_full_refusals++;
                if (want.status == skt_pkg::ST_DUP)
                    o_dup_refusals++;
                expected_rsp.push_back(want);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("status", i_rsp.status, want.status);
                    check_field("read_key", i_rsp.read_key, want.read_key);
                    check_field("read_grade", i_rsp.read_grade, want.read_grade);
                    check_field("read_name", i_rsp.read_name, want.read_name);
                    check_field("entry_count", i_rsp.entry_count, want.entry_count);
                    check_field("is_empty", i_rsp.is_empty, want.is_empty);
                    check_field("min_key", i_rsp.min_key, want.min_key);
                    check_field("max_key", i_rsp.max_key, want.max_key);
                    o_checked++;
                end
            end
        end
        o_pending = expected_rsp.size();
    end

endmodule

// File: tb/sv/sorted_key_table_tb.sv
`timescale 1ns / 100ps

module sorted_key_table_tb;

    localparam int PHASE_ITEMS   = 256;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 5;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_req_valid;
    logic          o_req_ready;
    skt_pkg::t_req i_req;
    logic          o_rsp_valid;
    logic          i_rsp_ready;
    skt_pkg::t_rsp o_rsp;

    int errors;
    int pending;
    int checked;
    int full_refusals;
    int dup_refusals;

    int idle_pct;
    int stall_pct;
    bit hold_off_req;
    bit hold_done;
    int n_inserts;
    int n_reads;
    int quiet_cycles;

    logic [31:0] used_keys [$];

    sorted_key_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    sorted_key_table_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .i_req_ready     (o_req_ready),
        .i_req           (i_req),
        .i_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .i_rsp           (o_rsp),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals),
        .o_dup_refusals  (dup_refusals)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic skt_pkg::t_req make_req(input skt_pkg::t_op op,
                                               input logic [31:0] key,
                                               input logic [31:0] grade,
                                               input logic [31:0] name,
                                               input logic [3:0] pos);
        skt_pkg::t_req r;
        r.op         = op;
        r.key        = key;
        r.grade_bits = grade;
        r.name_ref   = name;
        r.position   = pos;
        if (op == skt_pkg::OP_INSERT)
            used_keys.push_back(key);
        return r;
    endfunction

    // Mostly reads; inserts reuse a known key often enough to hit duplicates.
    function automatic skt_pkg::t_req random_request();
        skt_pkg::t_op op;
        logic [31:0]  key;
        op  = ($urandom_range(9) == 0) ? skt_pkg::OP_INSERT : skt_pkg::OP_READ;
        key = $urandom();
        if (op == skt_pkg::OP_INSERT && used_keys.size() != 0 && $urandom_range(2) == 0)
            key = used_keys[$urandom_range(used_keys.size() - 1)];
        return make_req(op, key, $urandom(), $urandom(), 4'($urandom_range(15)));
    endfunction

    task automatic send_request(input skt_pkg::t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        if (r.op == skt_pkg::OP_INSERT)
            n_inserts++;
        else
            n_reads++;
    endtask

    // Response side: random stalls, plus one long hold when asked.
    initial begin
        i_rsp_ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_rsp_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or response moved for %0d cycles",
                         STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int idle_by_phase  [4];
        int stall_by_phase [4];
        idle_by_phase  = '{0, 54, 0, 36};
        stall_by_phase = '{0, 0, 54, 36};
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off_req = 1'b0;
        n_inserts    = 0;
        n_reads      = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then ordering at the key extremes
        send_request(make_req(skt_pkg::OP_READ, '1, '1, '1, 4'd0));
        send_request(make_req(skt_pkg::OP_READ, '0, '0, '0, 4'd15));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h8000_0000, 32'h3f80_0000, 32'h1,
                              4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, '1,
                              4'd15));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h0, 32'h0, 32'h0, 4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h8000_0000, 32'h7fc0_0000, 32'h2,
                              4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h7fff_ffff, 32'h7f80_0000, 32'h3,
                              4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h8000_0001, 32'h8000_0000, 32'h4,
                              4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h1, 32'hff80_0000, 32'h5, 4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'hffff_fffe, 32'h0000_0001, 32'h6,
                              4'd0));
        send_request(make_req(skt_pkg::OP_READ, '0, '0, '0, 4'd0));
        send_request(make_req(skt_pkg::OP_READ, '0, '0, '0, 4'd6));
        send_request(make_req(skt_pkg::OP_READ, '0, '0, '0, 4'd7));
        // fill to capacity, then refuse a new key and a duplicate
        repeat (9)
            send_request(make_req(skt_pkg::OP_INSERT, $urandom(), $urandom(), $urandom(),
                                  4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h1234_5678, 32'h4049_0fdb, 32'h7,
                              4'd0));
        send_request(make_req(skt_pkg::OP_INSERT, 32'h0, 32'h0, 32'h8, 4'd0));
        send_request(make_req(skt_pkg::OP_READ, '0, '0, '0, 4'd15));

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            if (ph == 0)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_request(random_request());
        end

        i_req_valid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d inserts, %0d reads); %0d responses checked",
                 n_inserts + n_reads, n_inserts, n_reads, checked);
        $display("Refused inserts: %0d table full, %0d duplicate key; mismatches: %0d",
                 full_refusals, dup_refusals, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
